// ===== rtl/ir_glitch_fill_and_frame_gate_unit_defines.svh =====
// Assertion helpers used by the RTL file igf_back.sv.
`ifndef IR_GLITCH_FILL_AND_FRAME_GATE_UNIT_DEFINES_SVH
`define IR_GLITCH_FILL_AND_FRAME_GATE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define IGF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IGF_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define IGF_ASSERT(label, clk, rst_n, prop, msg)
`define IGF_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

// ===== rtl/igf_pkg.sv =====
package igf_pkg;

  localparam int GlitchLenDefault = 40;
  localparam int MidDepth         = 2;
  localparam int OutDepth         = 2;

  localparam int StartLenW = 10;
  localparam int EndLenW   = 12;
  localparam int LowRunW   = 11;
  localparam int HighRunW  = 13;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;

  localparam logic [StartLenW-1:0] StartLowLenRst = StartLenW'(198);
  localparam logic [EndLenW-1:0]   EndHighLenRst  = EndLenW'(692);
  localparam logic [LowRunW-1:0]   LowRunMax      = '1;
  localparam logic [HighRunW-1:0]  HighRunMax     = '1;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_START_LOW_LEN = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_END_HIGH_LEN  = CfgIdxW'(1);

  // item mode codes
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef struct packed {
    logic mode;
    logic sample;
  } in_item_t;

  typedef struct packed {
    logic level;
    logic frame_active;
    logic frame_start;
    logic frame_end;
  } out_item_t;

  // front to back: filtered bit or a restart marker
  typedef struct packed {
    logic restart;
    logic fill_bit;
  } mid_item_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/igf_fifo.sv =====
module igf_fifo #(
  parameter int Width = 2,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/igf_front.sv =====
module igf_front import igf_pkg::*; #(
  parameter int GlitchLen = GlitchLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output mid_item_t mid_o
);

  localparam int RunW = $clog2(GlitchLen + 1);
  localparam logic [RunW-1:0] RunMax = RunW'(GlitchLen);

  // line_q[0] holds the newest sample, line_q[GlitchLen-1] the oldest
  logic [GlitchLen-1:0] line_q, line_d;
  logic [RunW-1:0]      run_q, run_d;
  logic                 open_q, open_d;
  logic                 prev_q, prev_d;
  logic                 do_fill;
  logic                 restart;

  assign restart = (item_i.mode == MODE_RESTART);
  assign do_fill = item_i.sample && open_q && (run_q < RunMax);

  assign mid_o.restart  = restart;
  assign mid_o.fill_bit = line_q[GlitchLen-1];

  always_comb begin
    line_d = line_q;
    run_d  = run_q;
    open_d = open_q;
    prev_d = prev_q;
    if (accept_i) begin
      if (restart) begin
        line_d = '1;
        run_d  = '0;
        open_d = 1'b0;
        prev_d = 1'b1;
      end else begin
        // shift in, overwriting a short low run that just ended
        line_d[0] = item_i.sample;
        for (int j = 1; j < GlitchLen; j++) begin
          line_d[j] = line_q[j-1] | (do_fill && (RunW'(j - 1) < run_q));
        end
        if (item_i.sample) begin
          run_d  = '0;
          open_d = 1'b0;
        end else begin
          if (!open_q && prev_q) begin
            open_d = 1'b1;
          end
          if (run_q < RunMax) begin
            run_d = run_q + 1'b1;
          end
        end
        prev_d = item_i.sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '1;
      run_q  <= '0;
      open_q <= 1'b0;
      prev_q <= 1'b1;
    end else begin
      line_q <= line_d;
      run_q  <= run_d;
      open_q <= open_d;
      prev_q <= prev_d;
    end
  end

endmodule

// ===== rtl/igf_back.sv =====
`include "ir_glitch_fill_and_frame_gate_unit_defines.svh"

module igf_back import igf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_wr_t   cfg_i,
  input  logic      mid_empty_i,
  input  mid_item_t mid_i,
  output logic      mid_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  logic [StartLenW-1:0] start_len_q;
  logic [EndLenW-1:0]   end_len_q;

  logic                open_q, open_d;
  logic                prev_q, prev_d;
  logic [LowRunW-1:0]  low_q, low_d;
  logic [HighRunW-1:0] high_q, high_d;
  logic                has_res;
  logic                fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_len_q <= StartLowLenRst;
      end_len_q   <= EndHighLenRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_START_LOW_LEN: start_len_q <= cfg_i.data[StartLenW-1:0];
        CFG_END_HIGH_LEN:  end_len_q   <= cfg_i.data[EndLenW-1:0];
        default: ;
      endcase
    end
  end

  // idle highs and restarts leave no result
  assign has_res    = !mid_i.restart && (open_q || !mid_i.fill_bit);
  assign fire       = !mid_empty_i && (!has_res || !res_full_i);
  assign mid_pop_o  = fire;
  assign res_push_o = fire && has_res;

  always_comb begin
    open_d = open_q;
    prev_d = prev_q;
    low_d  = low_q;
    high_d = high_q;
    res_o.level        = mid_i.fill_bit;
    res_o.frame_start  = 1'b0;
    res_o.frame_end    = 1'b0;
    if (mid_i.restart) begin
      open_d = 1'b0;
      prev_d = 1'b1;
      low_d  = '0;
      high_d = '0;
    end else if (!open_q) begin
      if (mid_i.fill_bit) begin
        prev_d = 1'b1;
        low_d  = '0;
      end else begin
        if (!prev_q && (low_q != LowRunMax)) begin
          low_d = low_q + 1'b1;
        end
        if (low_d > LowRunW'(start_len_q)) begin
          open_d            = 1'b1;
          res_o.frame_start = 1'b1;
        end
        prev_d = 1'b0;
      end
    end else begin
      if (mid_i.fill_bit) begin
        if (prev_q && (high_q != HighRunMax)) begin
          high_d = high_q + 1'b1;
        end
      end else begin
        high_d = '0;
      end
      prev_d = mid_i.fill_bit;
      if (high_d > HighRunW'(end_len_q)) begin
        open_d          = 1'b0;
        high_d          = '0;
        res_o.frame_end = 1'b1;
      end
    end
    res_o.frame_active = open_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      prev_q <= 1'b1;
      low_q  <= '0;
      high_q <= '0;
    end else if (fire) begin
      open_q <= open_d;
      prev_q <= prev_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  `IGF_ASSERT(a_start_opens, clk_i, rst_ni, (res_push_o && res_o.frame_start) |-> res_o.frame_active, "frame start without open frame")
  `IGF_ASSERT_NEVER(a_start_end_excl, clk_i, rst_ni, res_push_o && res_o.frame_start && res_o.frame_end, "frame start and end together")
  `IGF_ASSERT(a_idle_high_clear, clk_i, rst_ni, !open_q |-> (high_q == '0), "high run kept while idle")
  `IGF_ASSERT(a_open_from_start, clk_i, rst_ni, $rose(open_q) |-> $past(res_push_o && res_o.frame_start), "frame opened without start mark")

endmodule

// ===== rtl/ir_glitch_fill_and_frame_gate_unit.sv =====
// Channel   Handshake                  Payload
// input     push / full                in_data_i  (mode, sample)
// result    empty / pop                out_data_o (level, frame_active, frame_start, frame_end)
// config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output queue has room; an item goes into the middle
// queue on the accepting edge, then the gate step moves its result into the output queue.
// Rate is set by the gate step and the two-entry queues on each side.
// Reset (async, active low) gives an all-ones glitch line, idle gate and default lengths.
// Restart items and idle highs produce no result. A stalled result side fills the
// output queue, then the middle queue, then raises full. Config is always ready.
module ir_glitch_fill_and_frame_gate_unit import igf_pkg::*; #(
  parameter int GlitchLen = GlitchLenDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_data_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  mid_item_t mid_in, mid_out;
  out_item_t res;
  cfg_wr_t   cfg_wr;
  logic      accept;
  logic      mid_empty, mid_pop;
  logic      res_full, res_push;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;
  assign accept       = push && !full;

  igf_front #(
    .GlitchLen(GlitchLen)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_data_i),
    .mid_o   (mid_in)
  );

  igf_fifo #(
    .Width($bits(mid_item_t)),
    .Depth(MidDepth)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (mid_in),
    .full_o (full),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .empty_o(mid_empty)
  );

  igf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .mid_empty_i(mid_empty),
    .mid_i      (mid_out),
    .mid_pop_o  (mid_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  igf_fifo #(
    .Width($bits(out_item_t)),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule
